// File: rtl/softmax_argmax_classifier_assert.svh
// Assertion macros for the softmax/argmax classifier.
// Used by the top level only; needs a clock and an active-high reset.
`ifndef SOFTMAX_ARGMAX_CLASSIFIER_ASSERT_SVH
`define SOFTMAX_ARGMAX_CLASSIFIER_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent
`define SMAX_ASSERT_SAME(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent checked in the cycle after the antecedent
`define SMAX_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/smax_pkg.sv
// Shared constants, types and control structs of the softmax/argmax classifier.
// No dependencies; every other file but the assertion header refers to it by scoped names.
package smax_pkg;

   // Beat field widths
   localparam int LOGIT_W = 16;
   localparam int TAG_W   = 32;
   localparam int LABEL_W = 10;
   localparam int PROB_W  = 16;

   // Default sizing
   localparam int MAX_CLASSES     = 1024;
   localparam int EXP_TABLE_DEPTH = 256;

   // Arithmetic
   localparam int SUM_W   = 27;              // Q11.16 running sum
   localparam int EXP_W   = 17;              // exp value in Q16, up to 1.0
   localparam int T_W     = 33;              // distance times log2(e)
   localparam logic [SUM_W-1:0] ONE_Q16 = 27'd65536;
   localparam logic [SUM_W-1:0] SUM_MAX = 27'h7FFFFFF;
   localparam logic [16:0] LOG2E_Q16 = 17'd94548;
   localparam longint LN2_Q30 = 64'sd744261118;
   localparam int EXP_ZERO_SHIFT = 17;       // shift at which exp flushes to zero
   localparam int DIV_STEPS = 33;            // quotient bits of 2^32 / sum
   localparam int DCNT_W = 6;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_EXP_MUL,
      ST_EXP_IDX,
      ST_EXP_LUT,
      ST_SCALE,
      ST_UPDATE,
      ST_DIVIDE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load_in;
      logic load_t;
      logic load_idx;
      logic load_e;
      logic load_scaled;
      logic update;
      logic finish;
      logic div_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic first;
      logic greater;
      logic last;
      logic div_last;
   } status_type;

endpackage

// File: rtl/smax_ifs.sv
// Valid/ready channel interfaces for the classifier's logit and result beats.
// Depends on smax_pkg for field widths.
interface smax_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [smax_pkg::LOGIT_W-1:0] logit;
   logic        [smax_pkg::TAG_W-1:0]   frame_tag;
   logic                                is_last;

   modport source (output valid, output logit, output frame_tag, output is_last, input ready);
   modport sink   (input valid, input logit, input frame_tag, input is_last, output ready);
endinterface

interface smax_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [smax_pkg::LABEL_W-1:0]  label;
   logic [smax_pkg::PROB_W-1:0]   probability;
   logic [smax_pkg::TAG_W-1:0]    frame_out;

   modport source (output valid, output label, output probability, output frame_out, input ready);
   modport sink   (input valid, input label, input probability, input frame_out, output ready);
endinterface

// File: rtl/smax_ctrl.sv
// Sequencer of the classifier: walks each logit beat through the datapath steps.
// Depends on smax_pkg (state enum, command and status structs).
module smax_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  smax_pkg::status_type status,
   output smax_pkg::cmd_type    cmd
);

   smax_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == smax_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         smax_pkg::ST_IDLE: begin
            if (req_valid) state_in = smax_pkg::ST_CHECK;
         end
         smax_pkg::ST_CHECK: begin
            if (status.full || status.first) state_in = smax_pkg::ST_UPDATE;
            else                             state_in = smax_pkg::ST_EXP_MUL;
         end
         smax_pkg::ST_EXP_MUL: state_in = smax_pkg::ST_EXP_IDX;
         smax_pkg::ST_EXP_IDX: state_in = smax_pkg::ST_EXP_LUT;
         smax_pkg::ST_EXP_LUT: begin
            if (status.greater) state_in = smax_pkg::ST_SCALE;
            else                state_in = smax_pkg::ST_UPDATE;
         end
         smax_pkg::ST_SCALE: state_in = smax_pkg::ST_UPDATE;
         smax_pkg::ST_UPDATE: begin
            if (status.last) state_in = smax_pkg::ST_DIVIDE;
            else             state_in = smax_pkg::ST_IDLE;
         end
         smax_pkg::ST_DIVIDE: begin
            if (status.div_last) state_in = smax_pkg::ST_EMIT;
         end
         smax_pkg::ST_EMIT: begin
            if (out_free) state_in = smax_pkg::ST_IDLE;
         end
         default: state_in = smax_pkg::ST_IDLE;
      endcase
   end

   // Datapath commands
   always_comb begin
      cmd = '0;
      case (state_ff)
         smax_pkg::ST_IDLE:    cmd.load_in     = req_valid;
         smax_pkg::ST_EXP_MUL: cmd.load_t      = 1'b1;
         smax_pkg::ST_EXP_IDX: cmd.load_idx    = 1'b1;
         smax_pkg::ST_EXP_LUT: cmd.load_e      = 1'b1;
         smax_pkg::ST_SCALE:   cmd.load_scaled = 1'b1;
         smax_pkg::ST_UPDATE: begin
            cmd.update = 1'b1;
            cmd.finish = status.last;
         end
         smax_pkg::ST_DIVIDE:  cmd.div_step    = 1'b1;
         smax_pkg::ST_EMIT:    cmd.out_load    = out_free;
         default:              cmd = '0;
      endcase
   end

   // Result valid: set on load, dropped when the beat is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load)   rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= smax_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: rtl/smax_datapath.sv
// Datapath of the classifier: running max, exp table lookup, rescaled sum,
// restoring divider for 1/sum and the result register. Depends on smax_pkg.
module smax_datapath #(
   parameter int MaxClasses    = smax_pkg::MAX_CLASSES,
   parameter int ExpTableDepth = smax_pkg::EXP_TABLE_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  smax_pkg::cmd_type                   cmd,
   output smax_pkg::status_type                status,
   input  logic signed [smax_pkg::LOGIT_W-1:0] in_logit,
   input  logic        [smax_pkg::TAG_W-1:0]   in_tag,
   input  logic                                in_last,
   output logic        [smax_pkg::LABEL_W-1:0] out_label,
   output logic        [smax_pkg::PROB_W-1:0]  out_prob,
   output logic        [smax_pkg::TAG_W-1:0]   out_frame
);

   localparam int CntW   = $clog2(MaxClasses + 1);
   localparam int IdxW   = $clog2(MaxClasses);
   localparam int KW     = $clog2(ExpTableDepth);
   localparam int KProdW = 24 + KW + 1;
   localparam int SumW   = smax_pkg::SUM_W;
   localparam int ExpW   = smax_pkg::EXP_W;

   typedef logic [ExpW-1:0] exp_rom_type [ExpTableDepth];

   // 2^(-k/depth) in Q16 from a nine-term series of exp(-x) in Q30
   function automatic exp_rom_type build_exp_rom();
      exp_rom_type rom;
      longint      x;
      longint      term;
      longint      acc;
      longint      prod;
      for (int k = 0; k < ExpTableDepth; k++) begin
         x    = (longint'(k) * smax_pkg::LN2_Q30) / ExpTableDepth;
         term = 64'sd1 << 30;
         acc  = term;
         for (int i = 1; i <= 8; i++) begin
            prod = (term * x) >>> 30;
            case (i)
               1:       term = prod;
               2:       term = prod / 2;
               3:       term = prod / 3;
               4:       term = prod / 4;
               5:       term = prod / 5;
               6:       term = prod / 6;
               7:       term = prod / 7;
               8:       term = prod / 8;
               default: term = prod;
            endcase
            if ((i % 2) == 1) acc = acc - term;
            else              acc = acc + term;
         end
         rom[k] = ExpW'((acc + 64'sd8192) >>> 14);
      end
      return rom;
   endfunction

   localparam exp_rom_type ExpRom = build_exp_rom();

   // Beat capture
   logic signed [smax_pkg::LOGIT_W-1:0] logit_ff;
   logic        [smax_pkg::TAG_W-1:0]   tag_ff;
   logic                                last_ff;

   // Running state
   logic signed [smax_pkg::LOGIT_W-1:0] best_ff, best_in;
   logic        [IdxW-1:0]              idx_ff, idx_in;
   logic        [SumW-1:0]              sum_ff, sum_in;
   logic        [CntW-1:0]              cnt_ff, cnt_in;

   // Exp pipeline
   logic [smax_pkg::T_W-1:0] t_ff;
   logic [KW-1:0]            k_ff;
   logic [4:0]               n_ff;
   logic                     zero_ff;
   logic [ExpW-1:0]          e_ff;
   logic [SumW-1:0]          scaled_ff;

   // Divider and result
   logic [SumW-1:0]               div_ff;
   logic [SumW-1:0]               rem_ff;
   logic [16:0]                   q_ff;
   logic                          ovf_ff;
   logic [smax_pkg::DCNT_W-1:0]   dcnt_ff;
   logic [smax_pkg::LABEL_W-1:0]  res_label_ff;
   logic [smax_pkg::TAG_W-1:0]    res_tag_ff;
   logic [smax_pkg::LABEL_W-1:0]  out_label_ff;
   logic [smax_pkg::PROB_W-1:0]   out_prob_ff;
   logic [smax_pkg::TAG_W-1:0]    out_frame_ff;

   logic signed [smax_pkg::LOGIT_W:0] diff;
   logic signed [smax_pkg::LOGIT_W:0] diff_neg;
   logic [smax_pkg::LOGIT_W-1:0]      distance;
   logic [smax_pkg::T_W-1:0]          t_in;
   logic [KProdW-1:0]                 kprod;
   logic [8:0]                        n_full;
   logic [ExpW-1:0]                   e_in;
   logic [43:0]                       prod;
   logic [SumW:0]                     lead_add;
   logic [SumW:0]                     tail_add;
   logic [SumW:0]                     rem_sh;
   logic                              ge;
   logic [SumW-1:0]                   rem_in;

   // Status
   assign status.full     = (cnt_ff >= CntW'(MaxClasses));
   assign status.first    = (cnt_ff == '0);
   assign status.greater  = (logit_ff > best_ff);
   assign status.last     = last_ff;
   assign status.div_last = (dcnt_ff == smax_pkg::DCNT_W'(smax_pkg::DIV_STEPS - 1));

   // Distance to the leader, always non-negative
   assign diff     = {logit_ff[smax_pkg::LOGIT_W-1], logit_ff}
                   - {best_ff[smax_pkg::LOGIT_W-1], best_ff};
   assign diff_neg = -diff;
   assign distance = diff[smax_pkg::LOGIT_W] ? diff_neg[smax_pkg::LOGIT_W-1:0]
                                              : diff[smax_pkg::LOGIT_W-1:0];

   // Exp: d*log2(e), then split into shift and table index, then lookup
   assign t_in   = {17'd0, distance} * smax_pkg::T_W'(smax_pkg::LOG2E_Q16);
   assign kprod  = KProdW'(t_ff[23:0]) * KProdW'(ExpTableDepth);
   assign n_full = t_ff[smax_pkg::T_W-1:24];
   assign e_in   = zero_ff ? '0 : (ExpRom[k_ff] >> n_ff);

   // Rescale product, Q16 truncated
   assign prod = 44'(sum_ff) * 44'(e_ff);

   // Saturating sums
   assign lead_add = {1'b0, scaled_ff} + {1'b0, smax_pkg::ONE_Q16};
   assign tail_add = {1'b0, sum_ff} + {{(SumW + 1 - ExpW){1'b0}}, e_ff};

   // Update of leader, index, sum and count
   always_comb begin
      best_in = best_ff;
      idx_in  = idx_ff;
      sum_in  = sum_ff;
      cnt_in  = cnt_ff;
      if (!status.full) begin
         cnt_in = cnt_ff + 1'b1;
         if (status.first) begin
            best_in = logit_ff;
            idx_in  = '0;
            sum_in  = smax_pkg::ONE_Q16;
         end else if (status.greater) begin
            best_in = logit_ff;
            idx_in  = cnt_ff[IdxW-1:0];
            sum_in  = lead_add[SumW] ? smax_pkg::SUM_MAX : lead_add[SumW-1:0];
         end else begin
            sum_in  = tail_add[SumW] ? smax_pkg::SUM_MAX : tail_add[SumW-1:0];
         end
      end
   end

   // Restoring divide of 2^32 by the sum, one quotient bit per step
   assign rem_sh = {rem_ff, (dcnt_ff == '0)};
   assign ge     = (rem_sh >= {1'b0, div_ff});
   assign rem_in = ge ? SumW'(rem_sh - {1'b0, div_ff}) : rem_sh[SumW-1:0];

   // Running state, cleared after the last logit of an image
   always_ff @(posedge clock) begin
      if (reset) begin
         best_ff <= '0;
         idx_ff  <= '0;
         sum_ff  <= '0;
         cnt_ff  <= '0;
         dcnt_ff <= '0;
      end else begin
         if (cmd.finish) begin
            best_ff <= '0;
            idx_ff  <= '0;
            sum_ff  <= '0;
            cnt_ff  <= '0;
            dcnt_ff <= '0;
         end else begin
            if (cmd.update) begin
               best_ff <= best_in;
               idx_ff  <= idx_in;
               sum_ff  <= sum_in;
               cnt_ff  <= cnt_in;
            end
            if (cmd.div_step) dcnt_ff <= dcnt_ff + 1'b1;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         logit_ff <= in_logit;
         tag_ff   <= in_tag;
         last_ff  <= in_last;
      end
      if (cmd.load_t) t_ff <= t_in;
      if (cmd.load_idx) begin
         k_ff    <= KW'(kprod >> 24);
         n_ff    <= n_full[4:0];
         zero_ff <= (n_full >= 9'(smax_pkg::EXP_ZERO_SHIFT));
      end
      if (cmd.load_e) e_ff <= e_in;
      if (cmd.load_scaled) scaled_ff <= prod[42:16];
      if (cmd.finish) begin
         div_ff       <= sum_in;
         rem_ff       <= '0;
         q_ff         <= '0;
         ovf_ff       <= 1'b0;
         res_label_ff <= smax_pkg::LABEL_W'(idx_in);
         res_tag_ff   <= tag_ff;
      end else if (cmd.div_step) begin
         rem_ff <= rem_in;
         q_ff   <= {q_ff[15:0], ge};
         ovf_ff <= ovf_ff | q_ff[16];
      end
      if (cmd.out_load) begin
         out_label_ff <= res_label_ff;
         out_prob_ff  <= (ovf_ff || q_ff[16]) ? '1 : q_ff[15:0];
         out_frame_ff <= res_tag_ff;
      end
   end

   assign out_label = out_label_ff;
   assign out_prob  = out_prob_ff;
   assign out_frame = out_frame_ff;

endmodule

// File: rtl/softmax_argmax_classifier.sv
// A logit beat passes IDLE, CHECK and UPDATE (first of an image, or past MaxClasses), adds EXP_MUL,
// EXP_IDX and EXP_LUT (not above the leader) and also SCALE (new leader), for the exp lookup and rescale chain.
// The last beat adds the restoring division for 1/sum and EMIT, which holds until the output register is free;
// the next image's first beat is taken while that result still waits in the output register.
// Reset (synchronous): clears leader, index, sum, count and sequencer; no result is pending.
// Depends on smax_pkg, smax_ifs, smax_ctrl, smax_datapath and the assertion macro header.
`include "softmax_argmax_classifier_assert.svh"

module softmax_argmax_classifier #(
   parameter int MaxClasses    = smax_pkg::MAX_CLASSES,
   parameter int ExpTableDepth = smax_pkg::EXP_TABLE_DEPTH
) (
   input logic        clock,
   input logic        reset,
   smax_req_if.sink   req_ch,
   smax_rsp_if.source rsp_ch
);

   smax_pkg::cmd_type    cmd;
   smax_pkg::status_type status;

   // Sequencer
   smax_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Arithmetic and result register
   smax_datapath #(
      .MaxClasses    (MaxClasses),
      .ExpTableDepth (ExpTableDepth)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .in_logit  (req_ch.logit),
      .in_tag    (req_ch.frame_tag),
      .in_last   (req_ch.is_last),
      .out_label (rsp_ch.label),
      .out_prob  (rsp_ch.probability),
      .out_frame (rsp_ch.frame_out)
   );

   // Checks
   `SMAX_ASSERT_SAME(a_no_overwrite, clock, reset, cmd.out_load, (!rsp_ch.valid || rsp_ch.ready), "result overwritten before taken")
   `SMAX_ASSERT_NEXT(a_clear_after_last, clock, reset, cmd.finish, status.first, "class count not cleared after last beat")
   `SMAX_ASSERT_NEXT(a_busy_after_accept, clock, reset, (req_ch.valid && req_ch.ready), !req_ch.ready, "beat taken while one is in flight")

endmodule
